/* rtl/mpf_pkg.sv */
// Shared constants, types and helpers for the integer formatter.
// Used by the channel interfaces, the digit unit, the top level and the checker.
package mpf_pkg;

  localparam int CHAR_W       = 8;
  localparam int ARG_FIELD_W  = 32;
  localparam int ARG_WIDTH_DEF = 32;

  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_C     = 8'h63;
  localparam logic [CHAR_W-1:0] CH_D     = 8'h64;
  localparam logic [CHAR_W-1:0] CH_O     = 8'h6f;
  localparam logic [CHAR_W-1:0] CH_U     = 8'h75;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_A     = 8'h61;

  localparam logic [1:0] OP_HOLD   = 2'd0;
  localparam logic [1:0] OP_DABBLE = 2'd1;
  localparam logic [1:0] OP_SHIFT  = 2'd2;

  typedef struct packed {
    logic [3:0] top_digit;
    logic       top_zero;
  } mpf_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d);
    logic [CHAR_W-1:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'h0, d};
    end else begin
      c = CH_A + {4'h0, d} - 8'd10;
    end
    return c;
  endfunction

endpackage

/* rtl/mpf_if.sv */
// Valid/ready channel interfaces for format input items and output characters.
// Depends on mpf_pkg for field widths.
interface mpf_in_if;
  import mpf_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CHAR_W-1:0]      fmt_char;
  logic [ARG_FIELD_W-1:0] arg_value;
  modport source (output valid, output fmt_char, output arg_value, input ready);
  modport sink (input valid, input fmt_char, input arg_value, output ready);
endinterface

interface mpf_out_if;
  import mpf_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] out_char;
  logic              last_char;
  modport source (output valid, output out_char, output last_char, input ready);
  modport sink (input valid, input out_char, input last_char, output ready);
endinterface

/* rtl/mpf_digit_unit.sv */
// Shared digit unit: BCD shift-and-add-3 step, shift of the digit row by one digit, or hold.
// Depends on mpf_pkg for op codes and the status struct.
module mpf_digit_unit #(
  parameter int ARG_WIDTH = mpf_pkg::ARG_WIDTH_DEF,
  parameter int NDIG      = (ARG_WIDTH + 2) / 3
) (
  input  logic [1:0]           op,
  input  logic [NDIG*4-1:0]    dig,
  input  logic [ARG_WIDTH-1:0] val,
  output logic [NDIG*4-1:0]    dig_nxt,
  output logic [ARG_WIDTH-1:0] val_nxt,
  output mpf_pkg::mpf_stat_t   stat
);
  import mpf_pkg::*;

  logic [NDIG*4-1:0] adj;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (dig[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = dig[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = dig[i*4 +: 4];
      end
    end
  end

  always_comb begin
    case (op)
      OP_DABBLE: begin
        dig_nxt = {adj[NDIG*4-2:0], val[ARG_WIDTH-1]};
        val_nxt = {val[ARG_WIDTH-2:0], 1'b0};
      end
      OP_SHIFT: begin
        dig_nxt = {dig[NDIG*4-5:0], 4'h0};
        val_nxt = val;
      end
      default: begin
        dig_nxt = dig;
        val_nxt = val;
      end
    endcase
  end

  assign stat.top_digit = dig[NDIG*4-1 -: 4];
  assign stat.top_zero  = (dig[NDIG*4-1 -: 4] == 4'h0);

endmodule

/* rtl/mini_printf_integer_formatter.sv */
// Minimal printf integer formatter: sequencer, digit row and output register.
// Depends on mpf_pkg, mpf_in_if, mpf_out_if and mpf_digit_unit.
//
// Usage:
//   in_ch carries one format byte with its argument word per item; out_ch
//   carries output characters, last_char marking the final one of an item.
//   An item is taken only while the sequencer is idle. A plain byte or a
//   completed %c or %% passes through S_ONE, which puts its character in
//   the output register once the slot is free and returns to idle.
//   %d and %u run the shared shift-and-add-3 unit for every argument bit,
//   then strip leading zero digits one per cycle, then send the sign and
//   one digit per cycle while the output slot is free.
//   %o and %x load the digit row directly, then strip leading zero digits
//   and send the digits with no sign.
//   A '%' or an unknown conversion byte is absorbed without leaving idle.
//   An output register parts the two sides: the next item is taken while a
//   finished character waits; a stalled receiver holds out_ch steady and
//   the sequencer waits for the slot to free.
//   Reset clears the pending conversion flag, the sequencer and out valid.
module mini_printf_integer_formatter #(
  parameter int ARG_WIDTH = mpf_pkg::ARG_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  mpf_in_if.sink    in_ch,
  mpf_out_if.source out_ch
);
  import mpf_pkg::*;

  localparam int NDIG      = (ARG_WIDTH + 2) / 3;
  localparam int DIG_W     = NDIG * 4;
  localparam int OCT_W     = NDIG * 3;
  localparam int BIT_CNT_W = $clog2(ARG_WIDTH + 1);
  localparam int DIG_CNT_W = $clog2(NDIG + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ONE  = 3'd1;
  localparam logic [2:0] S_DAB  = 3'd2;
  localparam logic [2:0] S_SKIP = 3'd3;
  localparam logic [2:0] S_SIGN = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]           state_r, state_nxt;
  logic                 pend_r, pend_nxt;
  logic                 neg_r, neg_nxt;
  logic [CHAR_W-1:0]    char_r, char_nxt;
  logic [ARG_WIDTH-1:0] val_r, val_nxt;
  logic [DIG_W-1:0]     dig_r, dig_nxt;
  logic [BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [DIG_CNT_W-1:0] dig_cnt_r, dig_cnt_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]    out_char_r, out_char_nxt;
  logic                 out_last_r, out_last_nxt;

  logic [ARG_WIDTH-1:0] arg_w;
  logic [OCT_W-1:0]     oct_pad;
  logic [DIG_W-1:0]     oct_dig;
  logic [DIG_W-1:0]     hex_dig;
  logic [1:0]           op;
  logic [DIG_W-1:0]     unit_dig;
  logic [ARG_WIDTH-1:0] unit_val;
  mpf_stat_t            stat;
  logic                 accept;
  logic                 slot_free;
  logic                 emit;
  logic [CHAR_W-1:0]    emit_char;
  logic                 emit_last;
  logic                 cnt_one;

  generate
    if (ARG_WIDTH <= ARG_FIELD_W) begin : g_arg_narrow
      assign arg_w = in_ch.arg_value[ARG_WIDTH-1:0];
    end else begin : g_arg_wide
      assign arg_w = {{(ARG_WIDTH-ARG_FIELD_W){1'b0}}, in_ch.arg_value};
    end
  endgenerate

  assign oct_pad = OCT_W'(arg_w);
  assign hex_dig = DIG_W'(arg_w);

  generate
    for (genvar i = 0; i < NDIG; i++) begin : g_oct
      assign oct_dig[i*4 +: 4] = {1'b0, oct_pad[i*3 +: 3]};
    end
  endgenerate

  mpf_digit_unit #(
    .ARG_WIDTH (ARG_WIDTH),
    .NDIG      (NDIG)
  ) u_unit (
    .op      (op),
    .dig     (dig_r),
    .val     (val_r),
    .dig_nxt (unit_dig),
    .val_nxt (unit_val),
    .stat    (stat)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign cnt_one     = (dig_cnt_r == DIG_CNT_W'(1));

  always_comb begin
    state_nxt   = state_r;
    pend_nxt    = pend_r;
    neg_nxt     = neg_r;
    char_nxt    = char_r;
    val_nxt     = val_r;
    dig_nxt     = dig_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    op          = OP_HOLD;
    emit        = 1'b0;
    emit_char   = char_r;
    emit_last   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (!pend_r) begin
            if (in_ch.fmt_char == CH_PCT) begin
              pend_nxt = 1'b1;
            end else begin
              char_nxt  = in_ch.fmt_char;
              state_nxt = S_ONE;
            end
          end else begin
            pend_nxt    = 1'b0;
            dig_cnt_nxt = DIG_CNT_W'(NDIG);
            bit_cnt_nxt = BIT_CNT_W'(ARG_WIDTH);
            neg_nxt     = 1'b0;
            case (in_ch.fmt_char)
              CH_C: begin
                char_nxt  = in_ch.arg_value[CHAR_W-1:0];
                state_nxt = S_ONE;
              end
              CH_PCT: begin
                char_nxt  = CH_PCT;
                state_nxt = S_ONE;
              end
              CH_D: begin
                neg_nxt   = arg_w[ARG_WIDTH-1];
                val_nxt   = arg_w[ARG_WIDTH-1] ? (~arg_w + 1'b1) : arg_w;
                dig_nxt   = '0;
                state_nxt = S_DAB;
              end
              CH_U: begin
                val_nxt   = arg_w;
                dig_nxt   = '0;
                state_nxt = S_DAB;
              end
              CH_O: begin
                dig_nxt   = oct_dig;
                state_nxt = S_SKIP;
              end
              CH_X: begin
                dig_nxt   = hex_dig;
                state_nxt = S_SKIP;
              end
              default: begin
                state_nxt = S_IDLE;
              end
            endcase
          end
        end
      end
      S_ONE: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = char_r;
          emit_last = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_DAB: begin
        op          = OP_DABBLE;
        dig_nxt     = unit_dig;
        val_nxt     = unit_val;
        bit_cnt_nxt = bit_cnt_r - BIT_CNT_W'(1);
        if (bit_cnt_r == BIT_CNT_W'(1)) begin
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        if (stat.top_zero && !cnt_one) begin
          op          = OP_SHIFT;
          dig_nxt     = unit_dig;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
        end else begin
          state_nxt = neg_r ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = CH_MINUS;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          emit        = 1'b1;
          emit_char   = digit_char(stat.top_digit);
          emit_last   = cnt_one;
          op          = OP_SHIFT;
          dig_nxt     = unit_dig;
          dig_cnt_nxt = dig_cnt_r - DIG_CNT_W'(1);
          if (cnt_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_char;
      out_last_nxt  = emit_last;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r      <= neg_nxt;
    char_r     <= char_nxt;
    val_r      <= val_nxt;
    dig_r      <= dig_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_char  = out_char_r;
  assign out_ch.last_char = out_last_r;

endmodule

/* rtl/mpf_checker.sv */
// Port-level checks for the integer formatter, bound to its top level.
// Depends on mpf_pkg for character codes.
module mpf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] fmt_char,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       last_char
);
  import mpf_pkg::*;

  logic pend_r;
  logic acc;
  logic is_num;
  logic is_known;

  assign acc      = in_valid && in_ready;
  assign is_num   = (fmt_char == CH_D) || (fmt_char == CH_U) ||
                    (fmt_char == CH_O) || (fmt_char == CH_X);
  assign is_known = is_num || (fmt_char == CH_C) || (fmt_char == CH_PCT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (acc) begin
      pend_r <= !pend_r && (fmt_char == CH_PCT);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(last_char))
    else $error("stalled output item changed");

  a_plain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && !pend_r && (fmt_char != CH_PCT) |=> !in_ready)
    else $error("plain byte did not occupy the sequencer");

  a_num_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc && pend_r && is_num |=> !in_ready)
    else $error("numeric conversion did not occupy the sequencer");

  a_unknown_free: assert property (@(posedge clk) disable iff (!rst_n)
    acc && pend_r && !is_known |=> in_ready)
    else $error("unknown conversion left the sequencer busy");

endmodule

bind mini_printf_integer_formatter mpf_checker u_mpf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .fmt_char  (in_ch.fmt_char),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_char  (out_ch.out_char),
  .last_char (out_ch.last_char)
);

/* dv/mpf_format_checker.sv */
`timescale 1ns / 1ps
// Character checker for the integer formatter: follows the pending '%' flag,
// predicts the characters of every accepted format item and compares in order.
// Depends on mpf_pkg and the mpf_in_if / mpf_out_if channel interfaces.
module mpf_format_checker #(
  parameter int ARG_W = mpf_pkg::ARG_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mpf_in_if           fmt_ch,
  mpf_out_if          char_ch,
  output int unsigned mismatches,
  output int unsigned chars_owed
);
  import mpf_pkg::*;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } fmt_char_t;

  localparam logic [63:0] ARG_MASK = (ARG_W >= 64) ? '1 : ((64'd1 << ARG_W) - 64'd1);

  logic      pct_armed;
  fmt_char_t owed_chars[$];

  task automatic note_mismatch(input string what);
    $display("%0t: char mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic predict_item(input logic [CHAR_W-1:0] fc,
                              input logic [ARG_FIELD_W-1:0] av);
    logic [CHAR_W-1:0] run[$];
    logic [CHAR_W-1:0] digs[$];
    logic [63:0]       mag;
    logic [3:0]        nib;
    int unsigned       radix;
    fmt_char_t         e;
    mag = 64'(av) & ARG_MASK;
    radix = 0;
    if (!pct_armed) begin
      if (fc == CH_PCT) begin
        pct_armed = 1'b1;
      end else begin
        run.push_back(fc);
      end
    end else begin
      pct_armed = 1'b0;
      case (fc)
        CH_C: run.push_back(mag[CHAR_W-1:0]);
        CH_D: begin
          if (mag[ARG_W-1]) begin
            run.push_back(CH_MINUS);
            mag = (~mag + 64'd1) & ARG_MASK;
          end
          radix = 10;
        end
        CH_U: radix = 10;
        CH_O: radix = 8;
        CH_X: radix = 16;
        CH_PCT: run.push_back(CH_PCT);
        default: ;
      endcase
    end
    if (radix != 0) begin
      do begin
        nib = 4'(mag % radix);
        digs.push_front((nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_A + 8'(nib) - 8'd10);
        mag = mag / radix;
      end while (mag != 0);
      foreach (digs[i]) run.push_back(digs[i]);
    end
    foreach (run[i]) begin
      e.ch   = run[i];
      e.last = (i == run.size() - 1);
      owed_chars.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    fmt_char_t want;
    if (!rst_n) begin
      pct_armed  = 1'b0;
      mismatches = 0;
      owed_chars.delete();
    end else begin
      if (char_ch.valid && char_ch.ready) begin
        if (owed_chars.size() == 0) begin
          note_mismatch($sformatf("unexpected char 0x%02h", char_ch.out_char));
        end else begin
          want = owed_chars.pop_front();
          if (char_ch.out_char !== want.ch)
            note_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                    char_ch.out_char, want.ch));
          if (char_ch.last_char !== want.last)
            note_mismatch($sformatf("last_char %b, want %b on 0x%02h",
                                    char_ch.last_char, want.last, want.ch));
        end
      end
      if (fmt_ch.valid && fmt_ch.ready)
        predict_item(fmt_ch.fmt_char, fmt_ch.arg_value);
    end
    chars_owed = owed_chars.size();
  end

endmodule

/* dv/tb_mini_printf_integer_formatter.sv */
`timescale 1ns / 1ps
// Top of the integer formatter testbench: clock, reset, bursty format item
// stimulus, a stalling character receiver and the verdict.
// Depends on mpf_pkg, the channel interfaces, the block and mpf_format_checker.
module tb_mini_printf_integer_formatter;
  import mpf_pkg::*;

  localparam int RANDOM_ITEMS = 300;

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned chars_owed;
  int unsigned burst_left;

  mpf_in_if  fmt_ch();
  mpf_out_if char_ch();

  mini_printf_integer_formatter i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (fmt_ch),
    .out_ch(char_ch)
  );

  mpf_format_checker i_char_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .fmt_ch    (fmt_ch),
    .char_ch   (char_ch),
    .mismatches(mismatches),
    .chars_owed(chars_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_mini_printf_integer_formatter NOT OK");
    $finish;
  end

  function automatic logic [ARG_FIELD_W-1:0] pick_arg();
    logic [ARG_FIELD_W-1:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 20);
      1: begin
        case ($urandom_range(0, 3))
          0: v = '0;
          1: v = '1;
          2: v = 32'h8000_0000;
          default: v = 32'h7fff_ffff;
        endcase
      end
      2: v = 32'd1 << $urandom_range(0, 31);
      3: v = ~32'($urandom_range(0, 20));
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic push_item(input logic [CHAR_W-1:0] fc, input logic [ARG_FIELD_W-1:0] av);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
      if (gap != 0) begin
        fmt_ch.valid     <= 1'b0;
        fmt_ch.fmt_char  <= $urandom();
        fmt_ch.arg_value <= $urandom();
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    fmt_ch.valid     <= 1'b1;
    fmt_ch.fmt_char  <= fc;
    fmt_ch.arg_value <= av;
    do @(posedge clk); while (!fmt_ch.ready);
    @(negedge clk);
  endtask

  initial begin
    int unsigned mode;
    int unsigned span;
    char_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        @(negedge clk);
        case (mode)
          0: char_ch.ready <= 1'b1;
          1: char_ch.ready <= 1'($urandom_range(0, 1));
          2: char_ch.ready <= ($urandom_range(0, 7) != 0);
          default: char_ch.ready <= ((k % 24) < 4);
        endcase
      end
    end
  end

  initial begin
    logic [CHAR_W-1:0] conv_set [6];
    int unsigned       sent;
    conv_set = '{CH_C, CH_D, CH_U, CH_O, CH_X, CH_PCT};
    burst_left = 0;
    rst_n            <= 1'b0;
    fmt_ch.valid     <= 1'b0;
    fmt_ch.fmt_char  <= '0;
    fmt_ch.arg_value <= '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    push_item("A", '0);
    push_item(8'h00, '1);
    push_item(8'hff, 32'h5a5a_5a5a);
    push_item(CH_PCT, '0);
    push_item(CH_PCT, '1);
    push_item(CH_PCT, '0);
    push_item(CH_C, 32'hffff_ff80);
    push_item(CH_PCT, '0);
    push_item(CH_D, '0);
    push_item(CH_PCT, '0);
    push_item(CH_D, 32'h8000_0000);
    push_item(CH_PCT, '0);
    push_item(CH_D, '1);
    push_item(CH_PCT, '0);
    push_item(CH_D, 32'h7fff_ffff);
    push_item(CH_PCT, '0);
    push_item(CH_U, '1);
    push_item(CH_PCT, '0);
    push_item(CH_O, '1);
    push_item(CH_PCT, '0);
    push_item(CH_X, 32'hdead_beef);
    push_item(CH_PCT, '0);
    push_item("s", 32'h1234_5678);
    push_item(CH_PCT, '0);
    push_item(8'h00, '1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          push_item(8'($urandom_range(0, 255)), $urandom());
          sent += 1;
        end
        9: begin
          push_item(CH_PCT, $urandom());
          push_item(8'($urandom_range(0, 255)), pick_arg());
          sent += 2;
        end
        default: begin
          push_item(CH_PCT, $urandom());
          push_item(conv_set[$urandom_range(0, 5)], pick_arg());
          sent += 2;
        end
      endcase
    end

    fmt_ch.valid <= 1'b0;
    wait (chars_owed == 0);
    repeat (100) @(posedge clk);
    if (mismatches == 0 && chars_owed == 0) begin
      $display("tb_mini_printf_integer_formatter OK");
    end else begin
      $display("tb_mini_printf_integer_formatter NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/mpf_pkg.sv
rtl/mpf_if.sv
rtl/mpf_digit_unit.sv
rtl/mini_printf_integer_formatter.sv
rtl/mpf_checker.sv
dv/mpf_format_checker.sv
dv/tb_mini_printf_integer_formatter.sv
